FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset
`define DLPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition never occurs outside reset
`define DLPS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/dlps_pkg.sv
// ---------------------------------------------------------------------------
// dlps_pkg
// Widths, reset values, register indexes and control types of the pitch
// shifter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlps_pkg;

  // Field and state widths
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 13;
  localparam int TAP_W      = 12;
  localparam int GAIN_W     = 16;
  localparam int DLY_W      = 13;
  localparam int ERR_W      = 16;
  localparam int ALPHA_W    = 15;
  localparam int OPND_W     = 17;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Crossfade weight divider: one quotient bit per cycle
  localparam int DIV_STEPS  = ALPHA_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Register reset values
  localparam logic [LEN_W-1:0]  WINDOW_LEN_RST = LEN_W'(4000);
  localparam logic [LEN_W-1:0]  MIX_LEN_RST    = LEN_W'(1339);
  localparam logic [TAP_W-1:0]  TAP_STEP_RST   = TAP_W'(1003);
  localparam logic [GAIN_W-1:0] DRY_GAIN_RST   = GAIN_W'(2048);
  localparam logic [GAIN_W-1:0] WET_GAIN_RST   = GAIN_W'(2048);
  localparam logic [ERR_W-1:0]  STEP_ERR_RST   = ERR_W'(2 * 1003 - 4000);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIX_LEN    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TAP_STEP   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN   = CFG_IDX_W'(4);

  // Operand pair of the shared multiplier
  typedef enum logic [1:0] {
    MUL_MIX,
    MUL_DRY,
    MUL_WET
  } mul_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     take;
    logic     mem_wr;
    logic     rd_near;
    logic     rd_far;
    logic     div_init;
    logic     div_step;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     mix_sum;
    logic     finish;
  } dlps_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mix_active;
    logic out_busy;
  } dlps_status_t;

endpackage

`default_nettype wire

FILE: rtl/dlps_ctrl.sv
// ---------------------------------------------------------------------------
// dlps_ctrl
// Sequencer that steps one sample through write, two tap reads, the weight
// division and the crossfade while the crossfade is active, and the gain mix.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlps_ctrl
  import dlps_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire dlps_status_t status_i,
  output dlps_cmd_t         cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WR   = 4'd1;
  localparam logic [3:0] S_RDN  = 4'd2;
  localparam logic [3:0] S_RDF  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_MIX  = 4'd5;
  localparam logic [3:0] S_MSUM = 4'd6;
  localparam logic [3:0] S_DRY  = 4'd7;
  localparam logic [3:0] S_WET  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  assign s_axis_tready = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_DRY;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.take = 1'b1;
          state_d    = S_WR;
        end
      end
      S_WR: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.div_init = 1'b1;
        state_d        = S_RDN;
      end
      S_RDN: begin
        cmd_o.rd_near = 1'b1;
        state_d       = S_RDF;
      end
      S_RDF: begin
        cmd_o.rd_far = 1'b1;
        cnt_d        = '0;
        state_d      = status_i.mix_active ? S_DIV : S_DRY;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_MIX;
        end
      end
      S_MIX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_MIX;
        state_d       = S_MSUM;
      end
      S_MSUM: begin
        cmd_o.mix_sum = 1'b1;
        state_d       = S_DRY;
      end
      S_DRY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DRY;
        state_d       = S_WET;
      end
      S_WET: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_WET;
        state_d       = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dlps_dpath.sv
// ---------------------------------------------------------------------------
// dlps_dpath
// Delay store, tap addressing, weight divider, shared multiplier, window
// state and output register of the pitch shifter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlps_dpath
  import dlps_pkg::*;
#(
  parameter int BUFFER_DEPTH = 8192
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [SAMPLE_W-1:0]        m_axis_tdata,
  input  wire dlps_cmd_t             cmd_i,
  output dlps_status_t               status_o
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int XW = ((AW > DLY_W) ? AW : DLY_W) + 1;

  // Configuration registers
  logic [LEN_W-1:0]  window_len_q, mix_len_q;
  logic [TAP_W-1:0]  tap_step_q;
  logic [GAIN_W-1:0] dry_gain_q, wet_gain_q;

  // Window state
  logic [AW-1:0]    wp_q;
  logic             wrapped_q;
  logic [LEN_W-1:0] phase_q;
  logic [DLY_W-1:0] near_q, far_q;
  logic [ERR_W-1:0] err_q;

  // Item payload
  logic        [SAMPLE_W-1:0] x_q;
  logic        [SAMPLE_W-1:0] mem_q [BUFFER_DEPTH];
  logic        [SAMPLE_W-1:0] rd_data_q;
  logic                       rd_ok_q;
  logic signed [SAMPLE_W-1:0] shifted_q;
  logic        [LEN_W-1:0]    rem_q;
  logic        [ALPHA_W-1:0]  quo_q;
  logic signed [PROD_W-1:0]   prod_q, acc_q;
  logic        [SAMPLE_W-1:0] out_q;
  logic                       out_vld_q;

  logic        [AW-1:0]       rd_idx;
  logic signed [SAMPLE_W-1:0] tap_val;
  logic        [LEN_W:0]      rem_dbl;
  logic signed [OPND_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]   mix_tot, out_tot;
  logic signed [PROD_W-13:0]  out_sh;
  logic        [SAMPLE_W-1:0] out_sat;
  logic                       adv;
  logic        [ERR_W-1:0]    err_add, err_next, err_restart;
  logic        [LEN_W-1:0]    phase_inc;

  // Map a tap delay to a store address behind the write position
  function automatic logic [AW-1:0] tap_idx(input logic [AW-1:0] wp,
                                            input logic [DLY_W-1:0] dly);
    logic [XW-1:0] dm;
    logic [XW-1:0] raw;
    dm = XW'(dly);
    if (dm >= XW'(BUFFER_DEPTH)) begin
      dm = dm - XW'(BUFFER_DEPTH);
    end
    raw = XW'(wp) + XW'(BUFFER_DEPTH) - dm;
    if (raw >= XW'(BUFFER_DEPTH)) begin
      raw = raw - XW'(BUFFER_DEPTH);
    end
    return raw[AW-1:0];
  endfunction

  assign status_o.mix_active = (phase_q < mix_len_q);
  assign status_o.out_busy   = out_vld_q && !m_axis_tready;
  assign m_axis_tvalid       = out_vld_q;
  assign m_axis_tdata        = out_q;

  // Entries not yet written since reset read as zero
  assign rd_idx  = cmd_i.rd_far ? tap_idx(wp_q, far_q) : tap_idx(wp_q, near_q);
  assign tap_val = rd_ok_q ? $signed(rd_data_q) : '0;

  // Delay store: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[wp_q] <= x_q;
    end
    if (cmd_i.rd_near || cmd_i.rd_far) begin
      rd_data_q <= mem_q[rd_idx];
      rd_ok_q   <= wrapped_q || (rd_idx <= wp_q);
    end
  end

  // Shared multiplier operands
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_MIX: begin
        mul_a = $signed({2'b00, quo_q});
        mul_b = OPND_W'(shifted_q) - OPND_W'(tap_val);
      end
      MUL_DRY: begin
        mul_a = $signed({1'b0, dry_gain_q});
        mul_b = OPND_W'($signed(x_q));
      end
      MUL_WET: begin
        mul_a = $signed({1'b0, wet_gain_q});
        mul_b = OPND_W'(shifted_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Crossfade: far * 2^15 + alpha * (near - far), floor by 2^15
  assign mix_tot = $signed({{(PROD_W - SAMPLE_W - ALPHA_W){tap_val[SAMPLE_W-1]}},
                            tap_val, {ALPHA_W{1'b0}}}) + prod_q;

  // Gain mix, floor by 2^12 and saturate
  assign out_tot = acc_q + prod_q;
  assign out_sh  = out_tot[PROD_W-1:12];
  always_comb begin
    priority if (out_sh > (PROD_W-12)'(32767)) begin
      out_sat = 16'h7FFF;
    end else if (out_sh < -(PROD_W-12)'(32768)) begin
      out_sat = 16'h8000;
    end else begin
      out_sat = out_sh[SAMPLE_W-1:0];
    end
  end

  assign rem_dbl = {rem_q, 1'b0};

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      x_q <= s_axis_tdata;
    end
    // near tap straight through, replaced by the crossfade when active
    if (cmd_i.rd_far) begin
      shifted_q <= tap_val;
    end
    if (cmd_i.mix_sum) begin
      shifted_q <= mix_tot[ALPHA_W+SAMPLE_W-1:ALPHA_W];
    end
    if (cmd_i.div_init) begin
      rem_q <= phase_q;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_dbl >= {1'b0, mix_len_q}) begin
        rem_q <= LEN_W'(rem_dbl - {1'b0, mix_len_q});
        quo_q <= {quo_q[ALPHA_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_dbl[LEN_W-1:0];
        quo_q <= {quo_q[ALPHA_W-2:0], 1'b0};
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
      if (cmd_i.mul_sel == MUL_WET) begin
        acc_q <= prod_q;
      end
    end
    if (cmd_i.finish) begin
      out_q <= out_sat;
    end
  end

  // Tap advance and error update
  assign adv         = !err_q[ERR_W-1] && (err_q != '0);
  assign err_add     = adv ? ERR_W'((ERR_W'(tap_step_q) - ERR_W'(window_len_q)) << 1)
                           : ERR_W'({tap_step_q, 1'b0});
  assign err_next    = err_q + err_add;
  assign err_restart = ERR_W'({tap_step_q, 1'b0}) - ERR_W'(window_len_q);
  assign phase_inc   = phase_q + 1'b1;

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WINDOW_LEN_RST;
      mix_len_q    <= MIX_LEN_RST;
      tap_step_q   <= TAP_STEP_RST;
      dry_gain_q   <= DRY_GAIN_RST;
      wet_gain_q   <= WET_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_LEN: window_len_q <= cfg_data_i[LEN_W-1:0];
        REG_MIX_LEN:    mix_len_q    <= cfg_data_i[LEN_W-1:0];
        REG_TAP_STEP:   tap_step_q   <= cfg_data_i[TAP_W-1:0];
        REG_DRY_GAIN:   dry_gain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_WET_GAIN:   wet_gain_q   <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Window state: advance taps, restart at the end of a window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      phase_q   <= '0;
      near_q    <= '0;
      far_q     <= DLY_W'(TAP_STEP_RST);
      err_q     <= STEP_ERR_RST;
    end else if (cmd_i.finish) begin
      if (wp_q == AW'(BUFFER_DEPTH - 1)) begin
        wp_q      <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wp_q <= wp_q + 1'b1;
      end
      if (phase_inc >= window_len_q) begin
        phase_q <= '0;
        near_q  <= '0;
        far_q   <= DLY_W'(tap_step_q);
        err_q   <= err_restart;
      end else begin
        phase_q <= phase_inc;
        near_q  <= adv ? near_q + 1'b1 : near_q;
        far_q   <= (adv && status_o.mix_active) ? far_q + 1'b1 : far_q;
        err_q   <= err_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/delay_line_pitch_shifter_top.sv
// ---------------------------------------------------------------------------
// delay_line_pitch_shifter_top
// Two-tap crossfading delay-line pitch shifter with dry/wet gain mix.
// ---------------------------------------------------------------------------
//   channel  | direction | contents
//   s_axis   | in        | tdata[15:0] sample_in
//   m_axis   | out       | tdata[15:0] sample_out
//   cfg      | in        | we, idx (register number), data[15:0]
//
// A sample is stored and its two taps are read one after another from the
// single-port delay store; while the crossfade is active, the weight divider
// resolves one quotient bit per cycle and the taps are crossfaded.
// One sample is in work at a time; the next is taken as soon as the result
// sits in the output register, which then waits for m_axis_tready.
// Reset is immediate: store entries not yet written read as zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module delay_line_pitch_shifter_top
  import dlps_pkg::*;
#(
  parameter int BUFFER_DEPTH = 8192
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,  // [15:0] sample_in
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [SAMPLE_W-1:0]        m_axis_tdata   // [15:0] sample_out
);

  dlps_cmd_t    cmd;
  dlps_status_t status;

  dlps_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  dlps_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

`default_nettype wire

FILE: rtl/dlps_checker.sv
// ---------------------------------------------------------------------------
// dlps_checker
// Port-level checks of request ordering and output hold on the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dlps_checker
  import dlps_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [SAMPLE_W-1:0] s_axis_tdata,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [SAMPLE_W-1:0] m_axis_tdata
);

  logic       in_req, out_req;
  logic [1:0] pend_q;

  assign in_req  = s_axis_tvalid && s_axis_tready;
  assign out_req = m_axis_tvalid && m_axis_tready;

  // Count requests taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_req && !out_req) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_req && !in_req) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // Hold a stalled result
  `DLPS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  // One request in work at a time
  `DLPS_ASSERT(a_one_in_work, in_req |=> !s_axis_tready, "input taken while busy")
  // No result without a pending request
  `DLPS_ASSERT_NEVER(a_no_phantom, m_axis_tvalid && (pend_q == 2'd0), "result without request")
  // At most one in work plus one held
  `DLPS_ASSERT_NEVER(a_pend_bound, pend_q == 2'd3, "too many requests pending")

  // Input payload is not checked here
  logic unused_in;
  assign unused_in = ^s_axis_tdata;

endmodule

bind delay_line_pitch_shifter_top dlps_checker u_dlps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: sim/tb_delay_line_pitch_shifter_top.sv
// ---------------------------------------------------------------------------
// tb_delay_line_pitch_shifter_top
// Self-checking bench for the two-tap crossfading pitch shifter. A short
// table of hand-picked samples and register writes runs first, then streams
// of random audio under several register settings. Every accepted sample is
// fed to a behavioural model of the delay store, the tap delays and the
// dry/wet mix, and each output is compared in order with the predicted one.
// Source bursts and sink stalls are randomised.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_delay_line_pitch_shifter_top;
  import dlps_pkg::*;

  localparam int STORE_DEPTH   = 8192;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int MAX_REPORTS   = 10;

  // Indexes outside the register map, expected to be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_C = CFG_IDX_W'(7);

  typedef enum logic {
    ROW_SAMPLE,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;  // register value or sample
    logic                  typed;
    logic [SAMPLE_W-1:0]   want;
  } drill_row_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_TOGGLE
  } sink_mode_e;

  // Directed table: reset state, saturation, ignored indexes, degenerate window
  localparam int DRILL_ROWS = 27;
  localparam drill_row_t DRILL [DRILL_ROWS] = '{
    '{ROW_SAMPLE, '0,             16'h7FFF, 1'b1, 16'h3FFF},
    '{ROW_SAMPLE, '0,             16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0,             16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0,             16'h0001, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0,             16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0,             16'h5555, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0,             16'hAAAA, 1'b0, 16'h0000},
    '{ROW_REG,    REG_DRY_GAIN,   16'hFFFF, 1'b0, 16'h0000},
    '{ROW_REG,    REG_WET_GAIN,   16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0,             16'h7FFF, 1'b1, 16'h7FFF},
    '{ROW_SAMPLE, '0,             16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, '0,             16'h0001, 1'b1, 16'h000F},
    '{ROW_SAMPLE, '0,             16'hFFFF, 1'b1, 16'hFFF0},
    '{ROW_SAMPLE, '0,             16'h0000, 1'b1, 16'h0000},
    '{ROW_REG,    REG_SPARE_A,    16'hFFFF, 1'b0, 16'h0000},
    '{ROW_REG,    REG_SPARE_B,    16'hFFFF, 1'b0, 16'h0000},
    '{ROW_REG,    REG_SPARE_C,    16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0,             16'h0001, 1'b1, 16'h000F},
    '{ROW_REG,    REG_WINDOW_LEN, 16'h0000, 1'b0, 16'h0000},
    '{ROW_REG,    REG_MIX_LEN,    16'h0000, 1'b0, 16'h0000},
    '{ROW_REG,    REG_TAP_STEP,   16'h0000, 1'b0, 16'h0000},
    '{ROW_REG,    REG_DRY_GAIN,   16'h0000, 1'b0, 16'h0000},
    '{ROW_REG,    REG_WET_GAIN,   16'h1000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0,             16'h1234, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0,             16'h1234, 1'b1, 16'h1234},
    '{ROW_SAMPLE, '0,             16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, '0,             16'h7FFF, 1'b1, 16'h7FFF}
  };

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_valid  = 1'b0;
  logic                  s_ready;
  logic [SAMPLE_W-1:0]   s_data   = '0;
  logic                  m_valid;
  logic                  m_ready  = 1'b0;
  logic [SAMPLE_W-1:0]   m_data;

  // Model state: delay store image, tap delays and register copies
  logic [SAMPLE_W-1:0] echo_img [STORE_DEPTH];
  int unsigned         head_pos;
  int unsigned         win_phase;
  int unsigned         near_dly;
  int unsigned         far_dly;
  logic [ERR_W-1:0]    slope_err;
  logic [LEN_W-1:0]    win_len_q;
  logic [LEN_W-1:0]    mix_len_q;
  logic [TAP_W-1:0]    tap_step_q;
  logic [GAIN_W-1:0]   dry_gain_q;
  logic [GAIN_W-1:0]   wet_gain_q;

  logic [SAMPLE_W-1:0] expected_out_q [$];
  logic [SAMPLE_W-1:0] head_want;
  bit                  settled = 1'b1;
  int                  fault_count = 0;
  int                  cycle_count = 0;
  sink_mode_e          sink_mode = SINK_OPEN;
  int                  sink_left = 0;

  delay_line_pitch_shifter_top #(
    .BUFFER_DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Return both taps and the error term to the start of a window
  function automatic void restart_window();
    win_phase = 0;
    near_dly  = 0;
    far_dly   = tap_step_q;
    slope_err = ERR_W'(2 * int'(tap_step_q) - int'(win_len_q));
  endfunction

  function automatic void reset_image();
    foreach (echo_img[i]) echo_img[i] = '0;
    head_pos   = 0;
    win_len_q  = WINDOW_LEN_RST;
    mix_len_q  = MIX_LEN_RST;
    tap_step_q = TAP_STEP_RST;
    dry_gain_q = DRY_GAIN_RST;
    wet_gain_q = WET_GAIN_RST;
    restart_window();
  endfunction

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_WINDOW_LEN: win_len_q  = val[LEN_W-1:0];
      REG_MIX_LEN:    mix_len_q  = val[LEN_W-1:0];
      REG_TAP_STEP:   tap_step_q = val[TAP_W-1:0];
      REG_DRY_GAIN:   dry_gain_q = val[GAIN_W-1:0];
      REG_WET_GAIN:   wet_gain_q = val[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // Delay 0 reads the sample just written
  function automatic longint tap_value(input int unsigned dly);
    int unsigned slot;
    slot = (head_pos + STORE_DEPTH - dly % STORE_DEPTH) % STORE_DEPTH;
    return longint'($signed(echo_img[slot]));
  endfunction

  // Store one sample, read the taps, crossfade and mix with the dry path
  function automatic logic [SAMPLE_W-1:0] shift_and_mix(input logic [SAMPLE_W-1:0] x);
    logic             bump;
    logic [ERR_W-1:0] err_down;
    logic [ERR_W-1:0] err_up;
    longint           dry_in;
    longint           weight;
    longint           pitched;
    longint           acc;
    dry_in   = longint'($signed(x));
    bump     = !slope_err[ERR_W-1] && (slope_err != '0);
    err_down = ERR_W'(2 * (int'(tap_step_q) - int'(win_len_q)));
    err_up   = ERR_W'(2 * int'(tap_step_q));
    echo_img[head_pos] = x;
    if (win_phase < mix_len_q) begin
      weight  = (longint'(win_phase) <<< 15) / longint'(mix_len_q);
      pitched = (weight * tap_value(near_dly)
                 + (32768 - weight) * tap_value(far_dly)) >>> 15;
      if (bump) begin
        near_dly = (near_dly + 1) & 'h1FFF;
        far_dly  = (far_dly + 1) & 'h1FFF;
      end
    end else begin
      pitched = tap_value(near_dly);
      if (bump) begin
        near_dly = (near_dly + 1) & 'h1FFF;
      end
    end
    slope_err = slope_err + (bump ? err_down : err_up);
    win_phase = (win_phase + 1) & 'h1FFF;
    if (win_phase >= win_len_q) begin
      restart_window();
    end
    head_pos = (head_pos + 1) % STORE_DEPTH;
    acc = (longint'(dry_gain_q) * dry_in + longint'(wet_gain_q) * pitched) >>> 12;
    if (acc > 32767) begin
      acc = 32767;
    end else if (acc < -32768) begin
      acc = -32768;
    end
    return SAMPLE_W'(acc);
  endfunction

  // Mostly full-range noise, with extremes and quiet passages mixed in
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return SAMPLE_W'($urandom_range(0, 64)) - 16'd32;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Drive one request and hold it until the block takes it
  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic typed,
                             input logic [SAMPLE_W-1:0] want);
    logic [SAMPLE_W-1:0] mixed;
    cfg_we  <= 1'b0;
    s_valid <= 1'b1;
    s_data  <= x;
    do @(posedge clk_i); while (!s_ready);
    mixed = shift_and_mix(x);
    expected_out_q.push_back(typed ? want : mixed);
    settled = 1'b0;
  endtask

  // Drop the source and wait until every output is back and the block is quiet
  task automatic settle_block();
    s_valid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    settled = 1'b1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    if (!settled) begin
      settle_block();
    end
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    set_register(idx, val);
    @(posedge clk_i);
  endtask

  // Send samples in bursts, with random gaps and occasional long runs
  task automatic stream_samples(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 64 : 12);
      if (burst > left) begin
        burst = left;
      end
      repeat (burst) send_sample(pick_sample(), 1'b0, '0);
      left -= burst;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] mix,
                           input logic [CFG_DATA_W-1:0] tap, input logic [CFG_DATA_W-1:0] dry,
                           input logic [CFG_DATA_W-1:0] wet, input int count);
    write_reg(REG_WINDOW_LEN, win);
    write_reg(REG_MIX_LEN, mix);
    write_reg(REG_TAP_STEP, tap);
    write_reg(REG_DRY_GAIN, dry);
    write_reg(REG_WET_GAIN, wet);
    stream_samples(count);
  endtask

  // Main sequence
  initial begin
    int               win;
    drill_row_t       row;
    reset_image();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DRILL_ROWS; r++) begin
      row = DRILL[r];
      if (row.kind == ROW_REG) begin
        write_reg(row.idx, row.value);
      end else begin
        send_sample(row.value, row.typed, row.want);
        if ($urandom_range(0, 1) == 0) begin
          s_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
    end

    // Short windows with crossfade, then the corners of the register ranges
    run_phase(16'd64, 16'd24, 16'd40, 16'd2048, 16'd2048, 200);
    run_phase(16'd20, 16'd20, 16'hFFFF, 16'h1000, 16'h1000, 150);
    run_phase(16'd8191, 16'd8191, 16'd4095, 16'hFFFF, 16'hFFFF, 200);
    run_phase(16'd1, 16'd1, 16'd0, 16'd3000, 16'd5000, 100);
    run_phase(16'd37, 16'd0, 16'd12, 16'h8000, 16'h0800, 150);
    run_phase(16'd100, 16'hFFFF, 16'd60, 16'd1024, 16'd6000, 150);
    run_phase(16'd4000, 16'd1339, 16'd1003, 16'd2048, 16'd2048, 200);
    repeat (3) begin
      win = $urandom_range(1, 600);
      run_phase(CFG_DATA_W'(win), CFG_DATA_W'($urandom_range(0, win + 50)),
                CFG_DATA_W'($urandom_range(0, 4095)), CFG_DATA_W'($urandom),
                CFG_DATA_W'($urandom), 150);
    end

    settle_block();
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Sink: stall pattern that changes mode after a random run
  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(0, 3));
      sink_left <= $urandom_range(32, 400);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:  m_ready <= 1'b1;
      SINK_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
      SINK_HEAVY: m_ready <= ($urandom_range(0, 3) == 0);
      default:    m_ready <= ~m_ready;
    endcase
  end

  // Compare each output with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      if (expected_out_q.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
          $display("unexpected output sample_out=%h", m_data);
        end
      end else begin
        head_want = expected_out_q.pop_front();
        if (m_data !== head_want) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("sample_out mismatch: expected %h, got %h", head_want, m_data);
          end
        end
      end
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
